// File: rtl/ehlo_extension_keyword_parser_macros.svh
// ---------------------------------------------------------------------------
// EHLO parser assertion macros
// Clocked assertion helpers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef EHLO_EXTENSION_KEYWORD_PARSER_MACROS_SVH
`define EHLO_EXTENSION_KEYWORD_PARSER_MACROS_SVH

// Concurrent assertion on clk, disabled while arst_n is low
`define EHLO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, for properties that do not need the reset guard
`define EHLO_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ehlo_pkg.sv
// ---------------------------------------------------------------------------
// EHLO parser package
// Parse phases, parser state, keyword table and the per-byte update functions.
// ---------------------------------------------------------------------------
package ehlo_pkg;

	localparam int NUM_KW = 7;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2d;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'd0,
		PH_PREFIX = 3'd1,
		PH_BLANK  = 3'd2,
		PH_TOKEN  = 3'd3,
		PH_EOL    = 3'd4
	} phase_t;

	typedef struct packed {
		logic                stopped;
		phase_t              phase;
		logic [1:0]          pcount;
		logic [3:0]          pos;
		logic [NUM_KW-1:0]   cand;
		logic [NUM_KW-1:0]   found;
	} parse_st_t;

	localparam parse_st_t ST_RESET = '{
		stopped: 1'b0,
		phase:   PH_FIRST,
		pcount:  2'd0,
		pos:     4'd0,
		cand:    {NUM_KW{1'b1}},
		found:   {NUM_KW{1'b0}}
	};

	// keywords left-justified in 16 characters, zero padded
	localparam logic [127:0] KW_ROW [NUM_KW] = '{
		{"8BITMIME",   64'h0},
		{"AUTH",       96'h0},
		{"DSN",        104'h0},
		{"PIPELINING", 48'h0},
		{"SIZE",       96'h0},
		{"SMTPUTF8",   64'h0},
		{"STARTTLS",   64'h0}
	};

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
		logic [127:0] row;
		row = KW_ROW[k];
		return row[8*(15-pos) +: 8];
	endfunction

	function automatic logic is_token_char(input logic [7:0] b);
		return (b == CH_DASH) || (b >= "0" && b <= "9") ||
			(b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	function automatic parse_st_t token_add(input parse_st_t st, input logic [7:0] b);
		parse_st_t  r;
		logic [7:0] c;
		r = st;
		c = (b >= "a" && b <= "z") ? (b - 8'd32) : b;
		for (int k = 0; k < NUM_KW; k++) begin
			if (kw_char(3'(k), st.pos) != c)
				r.cand[k] = 1'b0;
		end
		if (st.pos != 4'd15)
			r.pos = st.pos + 4'd1;
		return r;
	endfunction

	function automatic parse_st_t token_finish(input parse_st_t st);
		parse_st_t r;
		r = st;
		for (int k = 0; k < NUM_KW; k++) begin
			if (st.cand[k] && kw_char(3'(k), st.pos) == CH_NUL)
				r.found[k] = 1'b1;
		end
		return r;
	endfunction

	function automatic parse_st_t rest_of_line(input parse_st_t st, input logic [7:0] b);
		parse_st_t r;
		r = st;
		if (b == CH_NUL) begin
			r.stopped = 1'b1;
		end else if (b == CH_NL) begin
			r.phase  = PH_PREFIX;
			r.pcount = 2'd0;
		end else begin
			r.phase = PH_EOL;
		end
		return r;
	endfunction

endpackage

// File: rtl/ehlo_extension_keyword_parser.sv
// ---------------------------------------------------------------------------
// EHLO extension keyword parser
// Scans an SMTP EHLO/LHLO reply byte by byte and reports the extensions found.
// ---------------------------------------------------------------------------
// channel | signals                               | transaction
// --------+---------------------------------------+---------------------------
// data    | data_valid data_ready data_byte       | one reply byte
//         | last_byte                             |
// mask    | mask_valid mask_ready extension_mask  | one mask per reply
//
// One byte per cycle while the output is not stalled; a byte passes the
// input register, then the phase update, and its mask (last byte only)
// lands in the output register.
// Reset clears the parser state and both stage valids.
// Only a last byte waits on a full, stalled output register.
// ---------------------------------------------------------------------------
module ehlo_extension_keyword_parser
	import ehlo_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              data_valid,
	output logic              data_ready,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              mask_valid,
	input  logic              mask_ready,
	output logic [NUM_KW-1:0] extension_mask
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	parse_st_t         st_q;
	parse_st_t         st_step;
	parse_st_t         st_d;
	logic [NUM_KW-1:0] result;
	logic              go;
	logic              mask_valid_q;
	logic [NUM_KW-1:0] mask_q;

	assign go         = valid_s1 && (!last_s1 || !mask_valid_q || mask_ready);
	assign data_ready = !valid_s1 || go;
	assign mask_valid     = mask_valid_q;
	assign extension_mask = mask_q;

	always_comb begin
		st_step = st_q;
		if (!st_q.stopped) begin
			unique case (st_q.phase)
				PH_FIRST: begin
					if (byte_s1 == CH_NUL) begin
						st_step.stopped = 1'b1;
					end else if (byte_s1 == CH_NL) begin
						st_step.phase  = PH_PREFIX;
						st_step.pcount = 2'd0;
					end
				end
				PH_PREFIX: begin
					if (byte_s1 == CH_NUL) begin
						st_step.stopped = 1'b1;
					end else if (st_q.pcount == 2'd3) begin
						st_step.pcount = 2'd0;
						st_step.phase  = PH_BLANK;
					end else begin
						st_step.pcount = st_q.pcount + 2'd1;
					end
				end
				PH_BLANK: begin
					if (byte_s1 == CH_NUL) begin
						st_step.stopped = 1'b1;
					end else if (byte_s1 == CH_TAB || byte_s1 == CH_SPACE ||
						byte_s1 == CH_DASH) begin
						st_step = st_q;
					end else if (is_token_char(byte_s1)) begin
						st_step.pos   = 4'd0;
						st_step.cand  = {NUM_KW{1'b1}};
						st_step.phase = PH_TOKEN;
						st_step       = token_add(st_step, byte_s1);
					end else begin
						st_step = rest_of_line(st_q, byte_s1);
					end
				end
				PH_TOKEN: begin
					if (is_token_char(byte_s1))
						st_step = token_add(st_q, byte_s1);
					else
						st_step = rest_of_line(token_finish(st_q), byte_s1);
				end
				default: begin
					st_step = rest_of_line(st_q, byte_s1);
				end
			endcase
		end

		// end of reply inside a token still closes the token
		if (!st_step.stopped && st_step.phase == PH_TOKEN)
			result = token_finish(st_step).found;
		else
			result = st_step.found;

		st_d = last_s1 ? ST_RESET : st_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			st_q         <= ST_RESET;
			mask_valid_q <= 1'b0;
		end else begin
			if (data_ready)
				valid_s1 <= data_valid;
			if (go)
				st_q <= st_d;
			if (go && last_s1)
				mask_valid_q <= 1'b1;
			else if (mask_ready)
				mask_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (go && last_s1)
			mask_q <= result;
	end

endmodule

// File: rtl/ehlo_checker.sv
// ---------------------------------------------------------------------------
// EHLO parser checker
// Port-level assertions on the parser, bound to the top level.
// ---------------------------------------------------------------------------
`include "ehlo_extension_keyword_parser_macros.svh"

module ehlo_checker
	import ehlo_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              data_valid,
	input logic              data_ready,
	input logic [7:0]        data_byte,
	input logic              last_byte,
	input logic              mask_valid,
	input logic              mask_ready,
	input logic [NUM_KW-1:0] extension_mask
);

	logic [7:0] byte_seen;
	logic       last_seen;

	assign byte_seen = data_byte;
	assign last_seen = last_byte;

	// held mask must not change
	`EHLO_ASSERT(a_mask_hold, mask_valid && !mask_ready |=> mask_valid && $stable(extension_mask), "mask changed while stalled")

	// input only stalls behind a stalled result
	`EHLO_ASSERT(a_stall_cause, !data_ready |-> mask_valid && !mask_ready, "input stalled without a stalled result")

	// with nothing in flight, a taken result is not followed by another
	`EHLO_ASSERT(a_no_ghost, mask_valid && mask_ready && $past(data_ready) && !$past(data_valid) |=> !mask_valid, "result without a last byte")

	// bytes and last flags are known when taken
	`EHLO_ASSERT(a_known_in, data_valid && data_ready |-> !$isunknown(byte_seen) && !$isunknown(last_seen), "unknown input taken")

endmodule

bind ehlo_extension_keyword_parser ehlo_checker u_ehlo_checker (.*);
